// ===== sv/rgpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rgpd_pkg
// Shared types and constants of the rate group priority dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rgpd_pkg;

	localparam int NUM_PERIOD_REGS = 4;
	localparam int PERIOD_W        = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int GRP_W           = 2;
	localparam int ID_W            = 8;
	localparam int PRIO_W          = 8;
	localparam int ENTRY_W         = ID_W + PRIO_W;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET [NUM_PERIOD_REGS] =
		'{16'd1, 16'd5, 16'd10, 16'd100};

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_GROUP0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_GROUP1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_GROUP2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_GROUP3 = 2'd3;

	localparam logic REQ_REGISTER  = 1'b0;
	localparam logic REQ_TICK      = 1'b1;
	localparam logic KIND_DISPATCH = 1'b0;
	localparam logic KIND_REJECT   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REG_CHK,
		ST_REG_STEP,
		ST_REG_CMP,
		ST_TICK_GRP,
		ST_TICK_JOB
	} state_t;

	typedef struct packed {
		logic load_req;
		logic tick_go;
		logic rd_en;
		logic disp;
		logic wr_en;
		logic wr_new;
		logic fill_inc;
		logic reject;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic grp_ok;
		logic full;
		logic prio_ge;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/rgpd_dp.sv =====
// ----------------------------------------------------------------------------
// rgpd_dp
// Datapath: period registers, tick counters, fill counts, job table memory
// and the result word register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpd_dp import rgpd_pkg::*; #(
	parameter int GROUPS         = 4,
	parameter int JOBS_PER_GROUP = 8,
	localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1,
	localparam int SW    = (JOBS_PER_GROUP > 1) ? $clog2(JOBS_PER_GROUP) : 1,
	localparam int CW    = $clog2(JOBS_PER_GROUP + 1),
	localparam int DEPTH = GROUPS * JOBS_PER_GROUP,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [PERIOD_W-1:0]   cfg_wdata,
	input  wire  [GRP_W-1:0]      group,
	input  wire  [ID_W-1:0]       job_id,
	input  wire  [PRIO_W-1:0]     job_priority,
	input  wire  cmd_t            cmd,
	input  wire  [GW-1:0]         sel_grp,
	input  wire  [SW-1:0]         slot,
	output sts_t                  sts,
	output logic [CW-1:0]         fill_sel,
	output logic [GROUPS-1:0]     emit_mask,
	output logic [GW-1:0]         req_grp,
	output logic                  strobe,
	output logic                  kind,
	output logic [GRP_W-1:0]      out_group,
	output logic [ID_W-1:0]       out_job,
	output logic [PRIO_W-1:0]     out_priority,
	output logic                  last
);

	logic [PERIOD_W-1:0] period_q [NUM_PERIOD_REGS];
	logic [GRP_W-1:0]    req_grp_q;
	logic [ID_W-1:0]     req_id_q;
	logic [PRIO_W-1:0]   req_prio_q;
	logic [CW-1:0]       fill_q [GROUPS];
	logic [PERIOD_W-1:0] tick_q [GROUPS];
	logic [PERIOD_W-1:0] tick_nx [GROUPS];
	logic [GROUPS-1:0]   emit_q;
	logic [ENTRY_W-1:0]  mem_q [DEPTH];
	logic [ENTRY_W-1:0]  rd_q;
	logic [ENTRY_W-1:0]  wr_data;
	logic [AW-1:0]       addr;
	logic                disp_s1;
	logic                rej_s1;
	logic                last_s1;
	logic [GW-1:0]       grp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_PERIOD_REGS; r++) begin
				period_q[r] <= PERIOD_RESET[r];
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PERIOD_GROUP0: period_q[0] <= cfg_wdata;
				REG_PERIOD_GROUP1: period_q[1] <= cfg_wdata;
				REG_PERIOD_GROUP2: period_q[2] <= cfg_wdata;
				REG_PERIOD_GROUP3: period_q[3] <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_grp_q  <= group;
			req_id_q   <= job_id;
			req_prio_q <= job_priority;
		end
	end

	assign req_grp      = GW'(req_grp_q);
	assign fill_sel     = fill_q[sel_grp];
	assign emit_mask    = emit_q;
	assign sts.grp_ok   = 32'(req_grp_q) < GROUPS;
	assign sts.full     = fill_sel == CW'(JOBS_PER_GROUP);
	assign sts.prio_ge  = rd_q[PRIO_W-1:0] >= req_prio_q;

	for (genvar k = 0; k < GROUPS; k++) begin : g_tick
		logic [PERIOD_W-1:0] period_eff;
		logic [PERIOD_W:0]   tick_inc;
		if (k < NUM_PERIOD_REGS) begin : g_reg
			assign period_eff = (period_q[k] == '0) ? PERIOD_W'(1) : period_q[k];
		end else begin : g_fixed
			assign period_eff = PERIOD_W'(1);
		end
		assign tick_inc   = {1'b0, tick_q[k]} + (PERIOD_W+1)'(1);
		assign tick_nx[k] = (tick_inc >= {1'b0, period_eff}) ? '0 : tick_inc[PERIOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < GROUPS; k++) begin
				fill_q[k] <= '0;
				tick_q[k] <= '0;
			end
			emit_q <= '0;
		end else begin
			for (int k = 0; k < GROUPS; k++) begin
				if (cmd.fill_inc && req_grp == GW'(k)) begin
					fill_q[k] <= fill_q[k] + CW'(1);
				end
				if (cmd.tick_go) begin
					tick_q[k] <= tick_nx[k];
					emit_q[k] <= (tick_q[k] == '0) && (fill_q[k] != '0);
				end
			end
		end
	end

	assign addr    = AW'(32'(sel_grp) * JOBS_PER_GROUP + 32'(slot));
	assign wr_data = cmd.wr_new ? {req_id_q, req_prio_q} : rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_s1 <= 1'b0;
			rej_s1  <= 1'b0;
		end else begin
			disp_s1 <= cmd.disp;
			rej_s1  <= cmd.reject;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= cmd.last;
		grp_s1  <= sel_grp;
	end

	assign strobe       = disp_s1 | rej_s1;
	assign kind         = rej_s1 ? KIND_REJECT : KIND_DISPATCH;
	assign out_group    = rej_s1 ? req_grp_q : GRP_W'(grp_s1);
	assign out_job      = rej_s1 ? req_id_q : rd_q[ENTRY_W-1:PRIO_W];
	assign out_priority = rej_s1 ? req_prio_q : rd_q[PRIO_W-1:0];
	assign last         = rej_s1 ? 1'b1 : last_s1;

endmodule

`default_nettype wire

// ===== sv/rgpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rgpd_ctrl
// Controller: sequences sorted insertion of a job and the dispatch walk of
// released groups.
// ----------------------------------------------------------------------------
`default_nettype none

module rgpd_ctrl import rgpd_pkg::*; #(
	parameter int GROUPS         = 4,
	parameter int JOBS_PER_GROUP = 8,
	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1,
	localparam int SW = (JOBS_PER_GROUP > 1) ? $clog2(JOBS_PER_GROUP) : 1,
	localparam int CW = $clog2(JOBS_PER_GROUP + 1)
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire                req_type,
	output logic               busy,
	input  wire  sts_t         sts,
	input  wire  [CW-1:0]      fill_sel,
	input  wire  [GROUPS-1:0]  emit_mask,
	input  wire  [GW-1:0]      req_grp,
	output cmd_t               cmd,
	output logic [GW-1:0]      sel_grp,
	output logic [SW-1:0]      slot
);

	state_t        state_q, state_d;
	logic [GW-1:0] grp_q, grp_d;
	logic [SW-1:0] slot_q, slot_d;
	logic          more;
	logic          job_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grp_q   <= '0;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			grp_q   <= grp_d;
			slot_q  <= slot_d;
		end
	end

	assign busy = state_q != ST_IDLE;

	always_comb begin
		more = 1'b0;
		for (int k = 0; k < GROUPS; k++) begin
			if (k > int'(grp_q) && emit_mask[k]) begin
				more = 1'b1;
			end
		end
	end

	assign job_last = (CW'(slot_q) + CW'(1)) == fill_sel;

	always_comb begin
		state_d = state_q;
		grp_d   = grp_q;
		slot_d  = slot_q;
		cmd     = '0;
		sel_grp = grp_q;
		slot    = slot_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					if (req_type == REQ_TICK) begin
						cmd.tick_go = 1'b1;
						grp_d       = '0;
						state_d     = ST_TICK_GRP;
					end else begin
						state_d = ST_REG_CHK;
					end
				end
			end
			ST_REG_CHK: begin
				sel_grp = req_grp;
				if (!sts.grp_ok) begin
					state_d = ST_IDLE;
				end else if (sts.full) begin
					cmd.reject = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					slot_d  = SW'(fill_sel);
					state_d = ST_REG_STEP;
				end
			end
			ST_REG_STEP: begin
				sel_grp = req_grp;
				if (slot_q == '0) begin
					cmd.wr_en    = 1'b1;
					cmd.wr_new   = 1'b1;
					cmd.fill_inc = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					slot      = slot_q - SW'(1);
					state_d   = ST_REG_CMP;
				end
			end
			ST_REG_CMP: begin
				sel_grp   = req_grp;
				cmd.wr_en = 1'b1;
				if (sts.prio_ge) begin
					cmd.wr_new   = 1'b1;
					cmd.fill_inc = 1'b1;
					state_d      = ST_IDLE;
				end else begin
					slot_d  = slot_q - SW'(1);
					state_d = ST_REG_STEP;
				end
			end
			ST_TICK_GRP: begin
				if (emit_mask[grp_q]) begin
					slot_d  = '0;
					state_d = ST_TICK_JOB;
				end else if (grp_q == GW'(GROUPS - 1)) begin
					state_d = ST_IDLE;
				end else begin
					grp_d = grp_q + GW'(1);
				end
			end
			ST_TICK_JOB: begin
				cmd.rd_en = 1'b1;
				cmd.disp  = 1'b1;
				cmd.last  = job_last & ~more;
				if (job_last) begin
					if (more) begin
						grp_d   = grp_q + GW'(1);
						state_d = ST_TICK_GRP;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					slot_d = slot_q + SW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/rate_group_priority_dispatcher.sv =====
// ----------------------------------------------------------------------------
// rate_group_priority_dispatcher
// Rate group job tables with priority order and per-tick release dispatch.
// ----------------------------------------------------------------------------
// Usage: drive req_type, group, job_id and job_priority with start; the word
// is taken at a clock edge where start is high and busy is low. busy stays
// high while the word is processed.
// Register word: the job is inserted into its group's table by a walk from
// the tail that reads each entry of lower priority and rewrites it one slot
// up, then writes the job into the freed slot.
// A full table gives one reject word, registered from the check state.
// A group index at or above GROUPS is dropped without a result.
// Tick word: every tick counter advances at the accept edge. Released groups
// are then walked in index order, group by group and job by job; results
// appear one per cycle within a group from the table memory's single read
// port, each in the cycle after its read, and the final word of an item has
// last set. Results are shown for one cycle with strobe; the receiver cannot
// stall. Period registers are written through cfg_we/cfg_index/cfg_wdata
// only while idle, a rule for the user that the block leaves unchecked.
// Reset clears counters and fill counts and loads periods 1, 5, 10 and 100;
// the table memory is not cleared, unfilled slots are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_group_priority_dispatcher import rgpd_pkg::*; #(
	parameter int GROUPS         = 4,
	parameter int JOBS_PER_GROUP = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire                   req_type,
	input  wire  [GRP_W-1:0]      group,
	input  wire  [ID_W-1:0]       job_id,
	input  wire  [PRIO_W-1:0]     job_priority,
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [PERIOD_W-1:0]   cfg_wdata,
	output logic                  strobe,
	output logic                  kind,
	output logic [GRP_W-1:0]      out_group,
	output logic [ID_W-1:0]       out_job,
	output logic [PRIO_W-1:0]     out_priority,
	output logic                  last
);

	localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int SW = (JOBS_PER_GROUP > 1) ? $clog2(JOBS_PER_GROUP) : 1;
	localparam int CW = $clog2(JOBS_PER_GROUP + 1);

	cmd_t              cmd;
	sts_t              sts;
	logic [CW-1:0]     fill_sel;
	logic [GROUPS-1:0] emit_mask;
	logic [GW-1:0]     req_grp;
	logic [GW-1:0]     sel_grp;
	logic [SW-1:0]     slot;

	rgpd_ctrl #(
		.GROUPS         (GROUPS),
		.JOBS_PER_GROUP (JOBS_PER_GROUP)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.busy      (busy),
		.sts       (sts),
		.fill_sel  (fill_sel),
		.emit_mask (emit_mask),
		.req_grp   (req_grp),
		.cmd       (cmd),
		.sel_grp   (sel_grp),
		.slot      (slot)
	);

	rgpd_dp #(
		.GROUPS         (GROUPS),
		.JOBS_PER_GROUP (JOBS_PER_GROUP)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.group        (group),
		.job_id       (job_id),
		.job_priority (job_priority),
		.cmd          (cmd),
		.sel_grp      (sel_grp),
		.slot         (slot),
		.sts          (sts),
		.fill_sel     (fill_sel),
		.emit_mask    (emit_mask),
		.req_grp      (req_grp),
		.strobe       (strobe),
		.kind         (kind),
		.out_group    (out_group),
		.out_job      (out_job),
		.out_priority (out_priority),
		.last         (last)
	);

endmodule

`default_nettype wire

// ===== verif/tb_rate_group_priority_dispatcher.sv =====
// ----------------------------------------------------------------------------
// tb_rate_group_priority_dispatcher
// Self-checking bench for the rate group priority dispatcher. A directed table
// covers reset state, table ordering with equal priorities, the extremes of
// the id and priority fields and full-table rejects. Random words then run
// under several period settings, including zero, one and the maximum, with a
// lowered period catching a counter above it. Each word is predicted by a
// local model of the tables and tick counters, and every result word is
// compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rate_group_priority_dispatcher;
	import rgpd_pkg::*;

	localparam int NGRP        = 4;
	localparam int JOBS        = 8;
	localparam int SETTLE      = 48;
	localparam int IDLE_LIMIT  = 4000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 68;
	localparam int PRINT_CAP   = 40;

	typedef struct packed {
		logic              req;
		logic [GRP_W-1:0]  grp;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} order_t;

	typedef struct packed {
		logic              kind;
		logic [GRP_W-1:0]  grp;
		logic [ID_W-1:0]   job;
		logic [PRIO_W-1:0] prio;
		logic              last;
	} word_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} slot_t;

	typedef struct packed {
		order_t ord;
		logic   typed;
		logic   has_word;
		word_t  word;
	} row_t;

	typedef logic [PERIOD_W-1:0] period_set_t [NUM_PERIOD_REGS];

	localparam logic [CFG_IDX_W-1:0] PERIOD_REG [NUM_PERIOD_REGS] =
		'{REG_PERIOD_GROUP0, REG_PERIOD_GROUP1, REG_PERIOD_GROUP2, REG_PERIOD_GROUP3};
	localparam logic [PRIO_W-1:0] PRIO_LADDER [6] =
		'{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 start        = 1'b0;
	logic                 req_type     = 1'b0;
	logic [GRP_W-1:0]     group        = '0;
	logic [ID_W-1:0]      job_id       = '0;
	logic [PRIO_W-1:0]    job_priority = '0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [PERIOD_W-1:0]  cfg_wdata    = '0;
	logic                 busy;
	logic                 strobe;
	logic                 kind;
	logic [GRP_W-1:0]     out_group;
	logic [ID_W-1:0]      out_job;
	logic [PRIO_W-1:0]    out_priority;
	logic                 last;

	rate_group_priority_dispatcher uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.group        (group),
		.job_id       (job_id),
		.job_priority (job_priority),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.strobe       (strobe),
		.kind         (kind),
		.out_group    (out_group),
		.out_job      (out_job),
		.out_priority (out_priority),
		.last         (last)
	);

	logic [PERIOD_W-1:0] period_mirror [NUM_PERIOD_REGS];
	slot_t               roster [NGRP][JOBS];
	int                  roster_fill [NGRP];
	logic [PERIOD_W-1:0] tick_mirror [NGRP];
	word_t               step_words [$];
	word_t               due_words [$];
	row_t                plan [$];
	period_set_t         phase_sets [PHASES];

	int fault_count  = 0;
	int items_sent   = 0;
	int words_seen   = 0;
	int rejects_seen = 0;
	int idle_cycles  = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic flag_fault(input string what, input int got, input int want);
		fault_count++;
		if (fault_count <= PRINT_CAP) begin
			$display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
		end
	endtask

	task automatic dispatcher_step(input order_t o);
		int          pos;
		int          cnt;
		word_t       w;
		logic [PERIOD_W:0]   nxt;
		logic [PERIOD_W-1:0] per;
		step_words.delete();
		if (o.req == REQ_REGISTER) begin
			cnt = roster_fill[o.grp];
			if (cnt >= JOBS) begin
				w = '{KIND_REJECT, o.grp, o.id, o.prio, 1'b1};
				step_words.push_back(w);
			end else begin
				pos = 0;
				while (pos < cnt && roster[o.grp][pos].prio >= o.prio) begin
					pos++;
				end
				for (int i = cnt; i > pos; i--) begin
					roster[o.grp][i] = roster[o.grp][i-1];
				end
				roster[o.grp][pos] = '{o.id, o.prio};
				roster_fill[o.grp] = cnt + 1;
			end
		end else begin
			for (int g = 0; g < NGRP; g++) begin
				if (tick_mirror[g] == '0) begin
					for (int j = 0; j < roster_fill[g]; j++) begin
						w = '{KIND_DISPATCH, GRP_W'(g), roster[g][j].id, roster[g][j].prio, 1'b0};
						step_words.push_back(w);
					end
				end
				per = (period_mirror[g] == '0) ? PERIOD_W'(1) : period_mirror[g];
				nxt = tick_mirror[g] + 1'b1;
				tick_mirror[g] = (nxt >= per) ? '0 : nxt[PERIOD_W-1:0];
			end
			if (step_words.size() > 0) begin
				step_words[step_words.size()-1].last = 1'b1;
			end
		end
	endtask

	task automatic send_order(input order_t o, input int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		req_type     <= o.req;
		group        <= o.grp;
		job_id       <= o.id;
		job_priority <= o.prio;
		do @(posedge clk); while (busy);
		dispatcher_step(o);
		items_sent++;
	endtask

	task automatic settle_block();
		start <= 1'b0;
		while (due_words.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_periods(input period_set_t p);
		for (int i = 0; i < NUM_PERIOD_REGS; i++) begin
			cfg_we           <= 1'b1;
			cfg_index        <= PERIOD_REG[i];
			cfg_wdata        <= p[i];
			period_mirror[i]  = p[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned draw_gap(inout int stretch_left, inout bit stretch_quiet);
		if (stretch_left == 0) begin
			stretch_left  = $urandom_range(4, 16);
			stretch_quiet = ($urandom_range(0, 2) == 0);
		end
		stretch_left--;
		return stretch_quiet ? 0 : $urandom_range(0, 17);
	endfunction

	// check result words and watch for a stalled run
	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if (strobe) begin
				words_seen++;
				if (kind == KIND_REJECT) begin
					rejects_seen++;
				end
				if (due_words.size() == 0) begin
					flag_fault("unexpected word, job", out_job, 0);
				end else begin
					want = due_words.pop_front();
					if (kind !== want.kind) flag_fault("kind", kind, want.kind);
					if (out_group !== want.grp) flag_fault("out_group", out_group, want.grp);
					if (out_job !== want.job) flag_fault("out_job", out_job, want.job);
					if (out_priority !== want.prio) begin
						flag_fault("out_priority", out_priority, want.prio);
					end
					if (last !== want.last) flag_fault("last", last, want.last);
				end
			end
			if ((start && !busy) || strobe) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("** rate_group_priority_dispatcher: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		order_t      o;
		int          stretch_left;
		bit          stretch_quiet;
		int unsigned gap;

		stretch_left  = 0;
		stretch_quiet = 1'b0;
		for (int i = 0; i < NUM_PERIOD_REGS; i++) begin
			period_mirror[i] = PERIOD_RESET[i];
		end
		for (int g = 0; g < NGRP; g++) begin
			roster_fill[g] = 0;
			tick_mirror[g] = '0;
		end

		// reset state, ordering with ties, full table, extremes of id and priority
		plan.push_back('{'{REQ_TICK,     2'd0, 8'h00, 8'h00}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'h00, 8'h00}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'hFF, 8'hFF}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'h12, 8'h80}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'h34, 8'h80}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'h56, 8'h80}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'hAA, 8'h01}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'h55, 8'hFE}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'h77, 8'h00}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'hC3, 8'h5A}, 1'b1, 1'b1,
			'{KIND_REJECT, 2'd0, 8'hC3, 8'h5A, 1'b1}});
		plan.push_back('{'{REQ_REGISTER, 2'd0, 8'hFF, 8'hFF}, 1'b1, 1'b1,
			'{KIND_REJECT, 2'd0, 8'hFF, 8'hFF, 1'b1}});
		plan.push_back('{'{REQ_REGISTER, 2'd3, 8'hFF, 8'hFF}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd3, 8'h00, 8'hFF}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd1, 8'h01, 8'h7F}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd1, 8'h80, 8'h7F}, 1'b1, 1'b0, '0});
		plan.push_back('{'{REQ_REGISTER, 2'd2, 8'hFE, 8'h7F}, 1'b1, 1'b0, '0});
		repeat (5) begin
			plan.push_back('{'{REQ_TICK, 2'd3, 8'hFF, 8'hFF}, 1'b0, 1'b0, '0});
		end

		phase_sets[0] = '{16'd1, 16'd2, 16'd3, 16'hFFFF};
		phase_sets[1] = '{16'd0, 16'd4, 16'd2, 16'd3};
		phase_sets[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		phase_sets[3] = '{16'd7, 16'd1, 16'd0, 16'd2};
		for (int i = 0; i < NUM_PERIOD_REGS; i++) begin
			phase_sets[4][i] = PERIOD_W'($urandom_range(1, 9));
		end
		phase_sets[5] = '{16'd1, 16'd1, 16'd1, 16'd1};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			send_order(plan[k].ord, draw_gap(stretch_left, stretch_quiet));
			if (plan[k].typed) begin
				if (plan[k].has_word) begin
					due_words.push_back(plan[k].word);
				end
			end else begin
				foreach (step_words[n]) due_words.push_back(step_words[n]);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle_block();
			load_periods(phase_sets[ph]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				o.req  = ($urandom_range(0, 9) < 6) ? REQ_TICK : REQ_REGISTER;
				o.grp  = GRP_W'($urandom_range(0, NGRP - 1));
				o.id   = ID_W'($urandom());
				o.prio = $urandom_range(0, 1) ? PRIO_LADDER[$urandom_range(0, 5)]
				                              : PRIO_W'($urandom());
				gap = draw_gap(stretch_left, stretch_quiet);
				send_order(o, gap);
				foreach (step_words[n]) due_words.push_back(step_words[n]);
			end
		end

		settle_block();
		$display("run covered %0d input words over %0d period settings plus reset values",
			items_sent, PHASES);
		$display("checked %0d result words, %0d of them rejects, %0d mismatches",
			words_seen, rejects_seen, fault_count);
		if (fault_count == 0) begin
			$display("** rate_group_priority_dispatcher: PASSED **");
		end else begin
			$display("** rate_group_priority_dispatcher: FAILED **");
		end
		$finish;
	end

endmodule
